### rtl/wavhp_pkg.sv
// Shared types and constants of the WAV header parser.
// No dependencies; imported by the core, the result queue, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package wavhp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_TRUNC   = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_RIFF   = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE   = 3'd2;
    localparam logic [2:0] ERR_NO_FMT     = 3'd3;
    localparam logic [2:0] ERR_NOT_PCM    = 3'd4;
    localparam logic [2:0] ERR_NO_DATA    = 3'd5;
    localparam logic [2:0] ERR_SHORT_FMT  = 3'd6;

    // Result queue geometry
    localparam int RQ_DEPTH = 8;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [31:0] smp_rate;
        logic [15:0] channel_count;
        logic [15:0] bits_per_sample;
        logic [31:0] data_length;
        logic [2:0]  error_code;
        logic        last;
    } t_res;

    // Results produced by the parser for one byte; b only valid with a
    typedef struct packed {
        logic a_vld;
        logic b_vld;
        t_res a;
        t_res b;
    } t_push;

endpackage
`default_nettype wire

### rtl/wavhp_if.sv
// Handshake channel interfaces of the WAV header parser: byte input and result output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface wavhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface wavhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [31:0] smp_rate;
    logic [15:0] channel_count;
    logic [15:0] bits_per_sample;
    logic [31:0] data_length;
    logic [2:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output payload_byte, output smp_rate,
                    output channel_count, output bits_per_sample, output data_length,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input smp_rate,
                    input channel_count, input bits_per_sample, input data_length,
                    input error_code, input last, output ready);
endinterface
`default_nettype wire

### rtl/wavhp_core.sv
// Parser state machine: consumes one registered file byte per cycle while i_vld is high, emits 0..2 results.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wavhp_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_vld,
    input  wire [7:0]            i_byte,
    input  wire                  i_eoi,
    output wavhp_pkg::t_push     o_push
);
    import wavhp_pkg::*;

    localparam logic [3:0] PH_RIFF  = 4'd0;
    localparam logic [3:0] PH_RSIZE = 4'd1;
    localparam logic [3:0] PH_WAVE  = 4'd2;
    localparam logic [3:0] PH_ID    = 4'd3;
    localparam logic [3:0] PH_SIZE  = 4'd4;
    localparam logic [3:0] PH_FMT   = 4'd5;
    localparam logic [3:0] PH_SKIP  = 4'd6;
    localparam logic [3:0] PH_PAD   = 4'd7;
    localparam logic [3:0] PH_DATA  = 4'd8;
    localparam logic [3:0] PH_WAIT  = 4'd9;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_CORE = 32'd16;
    localparam logic [15:0] FMT_PCM  = 16'd1;

    logic [3:0]  r_phase,  n_phase;
    logic [3:0]  r_bcnt,   n_bcnt;
    logic [31:0] r_tag,    n_tag;
    logic [31:0] r_clen,   n_clen;
    logic        r_fmt_ok, n_fmt_ok;
    logic [15:0] r_ftag,   n_ftag;
    logic [15:0] r_chan,   n_chan;
    logic [31:0] r_rate,   n_rate;
    logic [15:0] r_depth,  n_depth;
    logic [31:0] r_rem,    n_rem;
    logic [31:0] r_cid,    n_cid;
    logic        r_pad,    n_pad;

    logic        emit_vld;
    t_res        emit_res;
    logic        eoi_vld;
    t_res        eoi_res;
    logic [31:0] skip_len;

    // Next state and results for the current byte
    always_comb begin
        n_phase  = r_phase;
        n_bcnt   = r_bcnt;
        n_tag    = r_tag;
        n_clen   = r_clen;
        n_fmt_ok = r_fmt_ok;
        n_ftag   = r_ftag;
        n_chan   = r_chan;
        n_rate   = r_rate;
        n_depth  = r_depth;
        n_rem    = r_rem;
        n_cid    = r_cid;
        n_pad    = r_pad;
        emit_vld = 1'b0;
        emit_res = '0;
        eoi_vld  = 1'b0;
        eoi_res  = '0;
        skip_len = r_clen - FMT_CORE;

        if (i_vld) begin
            unique case (r_phase)
                PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE: begin
                    n_tag  = {i_byte, r_tag[31:8]};
                    n_bcnt = r_bcnt + 4'd1;
                    if (r_bcnt == 4'd3) begin
                        n_bcnt = '0;
                        unique case (r_phase)
                            PH_RIFF: begin
                                if (n_tag != TAG_RIFF) begin
                                    emit_vld            = 1'b1;
                                    emit_res.kind       = KIND_ERROR;
                                    emit_res.error_code = ERR_NOT_RIFF;
                                    emit_res.last       = 1'b1;
                                    n_phase             = PH_WAIT;
                                end else begin
                                    n_phase = PH_RSIZE;
                                end
                            end
                            PH_RSIZE: n_phase = PH_WAVE;
                            PH_WAVE: begin
                                if (n_tag != TAG_WAVE) begin
                                    emit_vld            = 1'b1;
                                    emit_res.kind       = KIND_ERROR;
                                    emit_res.error_code = ERR_NOT_WAVE;
                                    emit_res.last       = 1'b1;
                                    n_phase             = PH_WAIT;
                                end else begin
                                    n_phase = PH_ID;
                                end
                            end
                            PH_ID: begin
                                n_cid   = n_tag;
                                n_phase = PH_SIZE;
                            end
                            default: begin
                                // Size field complete: dispatch on chunk id
                                n_clen = n_tag;
                                if (r_cid == TAG_FMT) begin
                                    if (n_tag < FMT_CORE) begin
                                        emit_vld            = 1'b1;
                                        emit_res.kind       = KIND_ERROR;
                                        emit_res.error_code = ERR_SHORT_FMT;
                                        emit_res.last       = 1'b1;
                                        n_phase             = PH_WAIT;
                                    end else begin
                                        n_phase = PH_FMT;
                                    end
                                end else if (r_cid == TAG_DATA) begin
                                    emit_vld = 1'b1;
                                    if (!r_fmt_ok) begin
                                        emit_res.kind       = KIND_ERROR;
                                        emit_res.error_code = ERR_NO_FMT;
                                        emit_res.last       = 1'b1;
                                        n_phase             = PH_WAIT;
                                    end else if (r_ftag != FMT_PCM) begin
                                        emit_res.kind       = KIND_ERROR;
                                        emit_res.error_code = ERR_NOT_PCM;
                                        emit_res.last       = 1'b1;
                                        n_phase             = PH_WAIT;
                                    end else begin
                                        n_rem                    = n_tag;
                                        emit_res.kind            = KIND_HEADER;
                                        emit_res.smp_rate        = r_rate;
                                        emit_res.channel_count   = r_chan;
                                        emit_res.bits_per_sample = r_depth;
                                        emit_res.data_length     = n_tag;
                                        emit_res.last            = (n_tag == '0);
                                        n_phase = (n_tag == '0) ? PH_WAIT : PH_DATA;
                                    end
                                end else begin
                                    n_rem   = n_tag;
                                    n_pad   = n_tag[0];
                                    n_phase = (n_tag != '0) ? PH_SKIP :
                                              (n_tag[0] ? PH_PAD : PH_ID);
                                end
                            end
                        endcase
                    end
                end
                PH_FMT: begin
                    // Capture the 16 core bytes of the fmt chunk
                    unique case (r_bcnt)
                        4'd0:    n_ftag  = {8'd0, i_byte};
                        4'd1:    n_ftag  = {i_byte, r_ftag[7:0]};
                        4'd2:    n_chan  = {8'd0, i_byte};
                        4'd3:    n_chan  = {i_byte, r_chan[7:0]};
                        4'd4:    n_rate  = {24'd0, i_byte};
                        4'd5:    n_rate  = {16'd0, i_byte, r_rate[7:0]};
                        4'd6:    n_rate  = {8'd0, i_byte, r_rate[15:0]};
                        4'd7:    n_rate  = {i_byte, r_rate[23:0]};
                        4'd14:   n_depth = {8'd0, i_byte};
                        4'd15:   n_depth = {i_byte, r_depth[7:0]};
                        default: ;
                    endcase
                    n_bcnt = r_bcnt + 4'd1;
                    if (r_bcnt == 4'd15) begin
                        n_bcnt   = '0;
                        n_fmt_ok = 1'b1;
                        n_rem    = skip_len;
                        n_pad    = r_clen[0];
                        n_phase  = (skip_len != '0) ? PH_SKIP :
                                   (r_clen[0] ? PH_PAD : PH_ID);
                    end
                end
                PH_SKIP: begin
                    n_rem = r_rem - 32'd1;
                    if (r_rem == 32'd1) begin
                        n_phase = r_pad ? PH_PAD : PH_ID;
                    end
                end
                PH_PAD: n_phase = PH_ID;
                PH_DATA: begin
                    n_rem                 = r_rem - 32'd1;
                    emit_vld              = 1'b1;
                    emit_res.kind         = KIND_PAYLOAD;
                    emit_res.payload_byte = i_byte;
                    emit_res.last         = (r_rem == 32'd1);
                    if (r_rem == 32'd1) begin
                        n_phase = PH_WAIT;
                    end
                end
                default: ;
            endcase

            // End of file: close out the stream and return to the reset state
            if (i_eoi) begin
                if (n_phase != PH_WAIT) begin
                    eoi_vld      = 1'b1;
                    eoi_res.last = 1'b1;
                    if (n_phase == PH_DATA) begin
                        eoi_res.kind = KIND_TRUNC;
                    end else begin
                        eoi_res.kind = KIND_ERROR;
                        if (n_phase == PH_RIFF) begin
                            eoi_res.error_code = ERR_NOT_RIFF;
                        end else if (n_phase == PH_RSIZE || n_phase == PH_WAVE) begin
                            eoi_res.error_code = ERR_NOT_WAVE;
                        end else begin
                            eoi_res.error_code = ERR_NO_DATA;
                        end
                    end
                end
                n_phase  = PH_RIFF;
                n_bcnt   = '0;
                n_tag    = '0;
                n_clen   = '0;
                n_fmt_ok = 1'b0;
                n_ftag   = '0;
                n_chan   = '0;
                n_rate   = '0;
                n_depth  = '0;
                n_rem    = '0;
                n_cid    = '0;
                n_pad    = 1'b0;
            end
        end
    end

    // Pack results so that slot a is filled first
    always_comb begin
        o_push.a_vld = emit_vld | eoi_vld;
        o_push.b_vld = emit_vld & eoi_vld;
        o_push.a     = emit_vld ? emit_res : eoi_res;
        o_push.b     = eoi_res;
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_RIFF;
            r_bcnt   <= '0;
            r_tag    <= '0;
            r_clen   <= '0;
            r_fmt_ok <= 1'b0;
            r_ftag   <= '0;
            r_chan   <= '0;
            r_rate   <= '0;
            r_depth  <= '0;
            r_rem    <= '0;
            r_cid    <= '0;
            r_pad    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_bcnt   <= n_bcnt;
            r_tag    <= n_tag;
            r_clen   <= n_clen;
            r_fmt_ok <= n_fmt_ok;
            r_ftag   <= n_ftag;
            r_chan   <= n_chan;
            r_rate   <= n_rate;
            r_depth  <= n_depth;
            r_rem    <= n_rem;
            r_cid    <= n_cid;
            r_pad    <= n_pad;
        end
    end

endmodule
`default_nettype wire

### rtl/wavhp_rq.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wavhp_rq (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire wavhp_pkg::t_push     i_push,
    input  wire                       i_pop,
    output wavhp_pkg::t_res           o_head,
    output logic [wavhp_pkg::RQ_AW:0] o_count
);
    import wavhp_pkg::*;

    t_res             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp, n_wp;
    logic [RQ_AW-1:0] r_rp, n_rp;
    logic [RQ_AW:0]   r_cnt, n_cnt;
    logic [RQ_AW-1:0] wp_b;

    always_comb begin
        wp_b  = r_wp + RQ_AW'(i_push.a_vld);
        n_wp  = r_wp + RQ_AW'(i_push.a_vld) + RQ_AW'(i_push.b_vld);
        n_rp  = r_rp + RQ_AW'(i_pop);
        n_cnt = r_cnt + (RQ_AW+1)'(i_push.a_vld) + (RQ_AW+1)'(i_push.b_vld)
                - (RQ_AW+1)'(i_pop);
    end

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.a_vld) begin
            r_mem[r_wp] <= i_push.a;
        end
        if (i_push.b_vld) begin
            r_mem[wp_b] <= i_push.b;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule
`default_nettype wire

### rtl/wav_header_parser.sv
// Order: a byte is registered on transfer and parsed in the next cycle; its results are
// written into the result queue and offered on the output from there, in order.
// Throughput: one byte per cycle unless stalled; a byte yields at most two results, and
// input stalls unless the 8-entry queue has room for them and for a byte in flight.
// Reset: synchronous active-low; parser returns to the RIFF tag search, queue empties.
// Top level of the WAV header parser. Depends on wavhp_pkg, wavhp_if, wavhp_core, wavhp_rq.
`timescale 1ns / 1ps
`default_nettype none
module wav_header_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    wavhp_in_if.sink    i_in,
    wavhp_out_if.source o_out
);
    import wavhp_pkg::*;

    logic           r_in_vld;
    logic [7:0]     r_in_byte;
    logic           r_in_eoi;
    t_push          push;
    t_res           head;
    logic [RQ_AW:0] rq_count;
    logic           in_xfer;
    logic           out_xfer;

    // Accept a byte only if the queue has room for two results beyond the byte in flight
    assign i_in.ready = ({1'b0, rq_count} + (r_in_vld ? (RQ_AW+2)'(2) : '0))
                        <= (RQ_AW+2)'(RQ_DEPTH - 2);
    assign in_xfer    = i_in.valid & i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_in.in_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    wavhp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_push  (push)
    );

    wavhp_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_xfer),
        .o_head  (head),
        .o_count (rq_count)
    );

    // Output channel
    assign o_out.valid           = (rq_count != '0);
    assign out_xfer              = o_out.valid & o_out.ready;
    assign o_out.kind            = head.kind;
    assign o_out.payload_byte    = head.payload_byte;
    assign o_out.smp_rate        = head.smp_rate;
    assign o_out.channel_count   = head.channel_count;
    assign o_out.bits_per_sample = head.bits_per_sample;
    assign o_out.data_length     = head.data_length;
    assign o_out.error_code      = head.error_code;
    assign o_out.last            = head.last;

    // Queue never overfills
    a_rq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_count <= (RQ_AW+1)'(RQ_DEPTH))
        else $error("result queue overflow");

    // A byte being parsed always finds room for two results
    a_rq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |-> rq_count <= (RQ_AW+1)'(RQ_DEPTH - 2))
        else $error("no room for results of parsed byte");

    // A second result for one byte is the end-of-file result and closes the stream
    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.b_vld |-> (push.a_vld && push.b.last && !push.a.last))
        else $error("bad second result");

    // Nothing is produced without a parsed byte
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> !push.a_vld)
        else $error("result without input");

endmodule
`default_nettype wire

### tb/sv/tb_wav_header_parser.sv
// Self-checking testbench for the WAV header parser: builds RIFF/WAVE files byte by byte,
// predicts every result and compares it with the block's output stream.
// Depends on wavhp_pkg, wavhp_if and wav_header_parser.
`timescale 1ns / 1ps

module tb_wav_header_parser;
    import wavhp_pkg::*;

    // Chunk tags as they read when four file bytes are taken little-endian
    localparam logic [31:0] TAG_RIFF = 32'h46464952;
    localparam logic [31:0] TAG_WAVE = 32'h45564157;
    localparam logic [31:0] TAG_FMT  = 32'h20746D66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;
    localparam logic [31:0] TAG_LIST = 32'h5453494C;
    localparam int unsigned FMT_CORE = 16;
    localparam logic [15:0] FORMAT_PCM = 16'd1;

    localparam int unsigned RANDOM_BYTES = 100;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef enum logic [3:0] {
        PS_RIFF_TAG, PS_RIFF_SIZE, PS_WAVE_TAG, PS_CHUNK_ID, PS_CHUNK_SIZE,
        PS_FMT_BODY, PS_SKIP, PS_PAD, PS_PAYLOAD, PS_DONE
    } t_parse_st;

    logic clk = 1'b0;
    logic rst_n;
    logic idle_on;

    wavhp_in_if  byte_if ();
    wavhp_out_if result_if ();

    wav_header_parser i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_if),
        .o_out   (result_if)
    );

    always #2 clk = ~clk;

    // Parser mirror
    t_parse_st    parse_st;
    int unsigned  tag_bytes;
    logic [31:0]  tag_word;
    logic [31:0]  chunk_tag;
    logic [31:0]  chunk_len;
    logic         fmt_valid;
    logic [15:0]  fmt_code;
    logic [15:0]  fmt_channels;
    logic [31:0]  fmt_rate;
    logic [15:0]  fmt_depth;
    logic [31:0]  bytes_left;
    logic         pad_pending;

    t_res pending_results[$];
    logic [7:0] file_buf[$];

    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned files_sent;
    int unsigned bytes_sent;
    int unsigned headers_seen;
    int unsigned payload_seen;
    int unsigned errors_seen;
    int unsigned truncs_seen;
    int unsigned stall_left;
    t_res got_res;
    t_res want_res;

    function automatic void reset_parser();
        parse_st     = PS_RIFF_TAG;
        tag_bytes    = 0;
        tag_word     = '0;
        chunk_tag    = '0;
        chunk_len    = '0;
        fmt_valid    = 1'b0;
        fmt_code     = '0;
        fmt_channels = '0;
        fmt_rate     = '0;
        fmt_depth    = '0;
        bytes_left   = '0;
        pad_pending  = 1'b0;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [7:0] b,
                                        input logic [2:0] err, input logic last);
        t_res r;
        r = '0;
        r.kind         = kind;
        r.payload_byte = b;
        if (kind == KIND_HEADER) begin
            r.smp_rate        = fmt_rate;
            r.channel_count   = fmt_channels;
            r.bits_per_sample = fmt_depth;
            r.data_length     = chunk_len;
        end
        r.error_code = err;
        r.last       = last;
        pending_results.push_back(r);
    endfunction

    function automatic void raise_error(input logic [2:0] err);
        push_result(KIND_ERROR, 8'h00, err, 1'b1);
        parse_st = PS_DONE;
    endfunction

    function automatic void start_skip(input logic [31:0] n, input logic pad);
        bytes_left  = n;
        pad_pending = pad;
        if (n == 0)
            parse_st = pad ? PS_PAD : PS_CHUNK_ID;
        else
            parse_st = PS_SKIP;
    endfunction

    // Advance the mirror by one accepted byte and queue the results it causes
    function automatic void parse_wav_byte(input logic [7:0] b, input logic eoi);
        case (parse_st)
            PS_RIFF_TAG, PS_RIFF_SIZE, PS_WAVE_TAG, PS_CHUNK_ID, PS_CHUNK_SIZE: begin
                tag_word = {b, tag_word[31:8]};
                tag_bytes++;
                if (tag_bytes == 4) begin
                    tag_bytes = 0;
                    case (parse_st)
                        PS_RIFF_TAG: begin
                            if (tag_word != TAG_RIFF) raise_error(ERR_NOT_RIFF);
                            else parse_st = PS_RIFF_SIZE;
                        end
                        PS_RIFF_SIZE: parse_st = PS_WAVE_TAG;
                        PS_WAVE_TAG: begin
                            if (tag_word != TAG_WAVE) raise_error(ERR_NOT_WAVE);
                            else parse_st = PS_CHUNK_ID;
                        end
                        PS_CHUNK_ID: begin
                            chunk_tag = tag_word;
                            parse_st  = PS_CHUNK_SIZE;
                        end
                        default: begin
                            chunk_len = tag_word;
                            if (chunk_tag == TAG_FMT) begin
                                if (chunk_len < FMT_CORE) raise_error(ERR_SHORT_FMT);
                                else parse_st = PS_FMT_BODY;
                            end else if (chunk_tag == TAG_DATA) begin
                                if (!fmt_valid) begin
                                    raise_error(ERR_NO_FMT);
                                end else if (fmt_code != FORMAT_PCM) begin
                                    raise_error(ERR_NOT_PCM);
                                end else begin
                                    bytes_left = chunk_len;
                                    push_result(KIND_HEADER, 8'h00, ERR_NONE, chunk_len == 0);
                                    parse_st = (chunk_len == 0) ? PS_DONE : PS_PAYLOAD;
                                end
                            end else begin
                                start_skip(chunk_len, chunk_len[0]);
                            end
                        end
                    endcase
                end
            end
            PS_FMT_BODY: begin
                // byte offsets within the fmt body
                case (tag_bytes)
                    0:  fmt_code           = {8'h00, b};
                    1:  fmt_code[15:8]     = b;
                    2:  fmt_channels       = {8'h00, b};
                    3:  fmt_channels[15:8] = b;
                    4:  fmt_rate           = {24'h0, b};
                    5:  fmt_rate[15:8]     = b;
                    6:  fmt_rate[23:16]    = b;
                    7:  fmt_rate[31:24]    = b;
                    14: fmt_depth          = {8'h00, b};
                    15: fmt_depth[15:8]    = b;
                    default: ;
                endcase
                tag_bytes++;
                if (tag_bytes >= FMT_CORE) begin
                    tag_bytes = 0;
                    fmt_valid = 1'b1;
                    start_skip(chunk_len - FMT_CORE, chunk_len[0]);
                end
            end
            PS_SKIP: begin
                bytes_left--;
                if (bytes_left == 0)
                    parse_st = pad_pending ? PS_PAD : PS_CHUNK_ID;
            end
            PS_PAD: parse_st = PS_CHUNK_ID;
            PS_PAYLOAD: begin
                bytes_left--;
                push_result(KIND_PAYLOAD, b, ERR_NONE, bytes_left == 0);
                if (bytes_left == 0)
                    parse_st = PS_DONE;
            end
            default: ;
        endcase

        // end of file: close out anything still open, then start over
        if (eoi) begin
            case (parse_st)
                PS_DONE: ;
                PS_PAYLOAD: push_result(KIND_TRUNC, 8'h00, ERR_NONE, 1'b1);
                PS_RIFF_TAG: push_result(KIND_ERROR, 8'h00, ERR_NOT_RIFF, 1'b1);
                PS_RIFF_SIZE, PS_WAVE_TAG: push_result(KIND_ERROR, 8'h00, ERR_NOT_WAVE, 1'b1);
                default: push_result(KIND_ERROR, 8'h00, ERR_NO_DATA, 1'b1);
            endcase
            reset_parser();
        end
    endfunction

    // File construction
    function automatic void put_u16(input logic [15:0] v);
        file_buf.push_back(v[7:0]);
        file_buf.push_back(v[15:8]);
    endfunction

    function automatic void put_u32(input logic [31:0] v);
        put_u16(v[15:0]);
        put_u16(v[31:16]);
    endfunction

    function automatic void put_random(input int unsigned n);
        repeat (n) file_buf.push_back(8'($urandom));
    endfunction

    function automatic void start_file();
        file_buf.delete();
        put_u32(TAG_RIFF);
        put_u32($urandom);
        put_u32(TAG_WAVE);
    endfunction

    function automatic void put_fmt(input logic [31:0] size, input logic [15:0] code,
                                    input logic [15:0] ch, input logic [31:0] rate,
                                    input logic [15:0] depth);
        put_u32(TAG_FMT);
        put_u32(size);
        if (size >= FMT_CORE) begin
            put_u16(code);
            put_u16(ch);
            put_u32(rate);
            put_random(6);      // byte rate and block align are not captured
            put_u16(depth);
            put_random(size - FMT_CORE);
            if (size[0]) put_random(1);
        end else begin
            put_random(size);
        end
    endfunction

    function automatic void put_other(input logic [31:0] id, input logic [31:0] size);
        put_u32(id);
        put_u32(size);
        put_random(size);
        if (size[0]) put_random(1);
    endfunction

    function automatic void put_data(input logic [31:0] size, input int unsigned n);
        put_u32(TAG_DATA);
        put_u32(size);
        put_random(n);
    endfunction

    function automatic void cut_file(input int unsigned n);
        while (file_buf.size() > n) void'(file_buf.pop_back());
    endfunction

    // One byte transfer, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            byte_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        byte_if.valid        = 1'b1;
        byte_if.in_byte      = b;
        byte_if.end_of_input = eoi;
        @(posedge clk);
        while (byte_if.ready !== 1'b1) @(posedge clk);
        parse_wav_byte(b, eoi);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], i == file_buf.size() - 1);
        files_sent++;
    endtask

    task automatic build_random_file();
        int unsigned pick;
        int unsigned n;
        logic [15:0] code;
        pick = $urandom_range(0, 99);
        code = ($urandom_range(0, 9) == 0) ? 16'($urandom) : FORMAT_PCM;
        start_file();
        repeat ($urandom_range(0, 2)) put_other($urandom, $urandom_range(0, 7));
        // a few files leave fmt out so that data comes first
        if (pick >= 6) begin
            if (pick < 12)
                put_fmt($urandom_range(0, 15), code, 16'($urandom), $urandom,
                        16'($urandom));
            else
                put_fmt($urandom_range(16, 21), code, 16'($urandom), $urandom,
                        16'($urandom));
            if ($urandom_range(0, 7) == 0)
                put_fmt($urandom_range(16, 19), FORMAT_PCM, 16'($urandom), $urandom,
                        16'($urandom));
        end
        repeat ($urandom_range(0, 1)) put_other($urandom, $urandom_range(0, 5));
        n = $urandom_range(0, 14);
        put_data(n, n);
        put_random($urandom_range(0, 3));
        // broken variants: flipped bit in the RIFF tag, RIFF size or WAVE tag, or the file ends early
        if (pick >= 12 && pick < 18)
            file_buf[$urandom_range(0, 11)] ^= 8'h01 << $urandom_range(0, 7);
        if (pick >= 18 && pick < 34)
            cut_file($urandom_range(1, file_buf.size()));
    endtask

    task automatic test_valid_file();
        start_file();
        put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 16'd16);
        put_data(4, 4);
        send_file();
        // empty payload ends the file at the header; trailing bytes are ignored
        start_file();
        put_fmt(16, FORMAT_PCM, 16'd1, 32'd8000, 16'd8);
        put_data(0, 0);
        put_random(3);
        send_file();
    endtask

    task automatic test_tag_errors();
        start_file();
        file_buf[3] = 8'h58;
        put_fmt(16, FORMAT_PCM, 16'd1, 32'd8000, 16'd8);
        send_file();
        start_file();
        file_buf[11] = 8'h58;
        put_fmt(16, FORMAT_PCM, 16'd1, 32'd8000, 16'd8);
        send_file();
    endtask

    task automatic test_chunk_errors();
        // data ahead of fmt
        start_file();
        put_data(4, 4);
        send_file();
        // non-PCM format
        start_file();
        put_fmt(16, 16'd3, 16'd2, 32'd48000, 16'd32);
        put_data(4, 4);
        send_file();
        // fmt too short, one just under and one empty
        start_file();
        put_fmt(15, FORMAT_PCM, 16'd1, 32'd8000, 16'd8);
        put_data(2, 2);
        send_file();
        start_file();
        put_fmt(0, FORMAT_PCM, 16'd1, 32'd8000, 16'd8);
        send_file();
        // file ends with no data chunk
        start_file();
        put_fmt(16, FORMAT_PCM, 16'd1, 32'd8000, 16'd8);
        put_other(TAG_LIST, 2);
        send_file();
    endtask

    task automatic test_odd_and_repeated();
        // odd sizes carry a pad byte; the later fmt replaces the earlier one
        start_file();
        put_other(TAG_LIST, 3);
        put_fmt(17, 16'd3, 16'd6, 32'd96000, 16'd24);
        put_fmt(18, FORMAT_PCM, 16'd2, 32'd48000, 16'd24);
        put_other(TAG_LIST, 0);
        put_data(5, 5);
        send_file();
    endtask

    task automatic test_field_extremes();
        // all-ones fields with a huge payload cut short, all-zero fields, format codes FFFF and 0
        start_file();
        put_fmt(16, FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        put_data(32'hFFFF_FFFF, 6);
        send_file();
        start_file();
        put_fmt(16, FORMAT_PCM, 16'h0000, 32'h0000_0000, 16'h0000);
        put_data(1, 1);
        send_file();
        start_file();
        put_fmt(16, 16'hFFFF, 16'd1, 32'd8000, 16'd8);
        put_data(2, 2);
        send_file();
        start_file();
        put_fmt(16, 16'h0000, 16'd1, 32'd8000, 16'd8);
        put_data(2, 2);
        send_file();
    endtask

    task automatic test_early_end();
        int unsigned cuts[7] = '{2, 6, 10, 14, 18, 24, 48};
        // one-byte file
        file_buf.delete();
        put_random(1);
        send_file();
        // end inside each header region and inside the payload
        foreach (cuts[i]) begin
            start_file();
            put_fmt(16, FORMAT_PCM, 16'd2, 32'd22050, 16'd16);
            put_data(8, 8);
            cut_file(cuts[i]);
            send_file();
        end
        // end while skipping an unknown chunk
        start_file();
        put_other(TAG_LIST, 10);
        cut_file(24);
        send_file();
    endtask

    task automatic test_random_files();
        int unsigned first;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                file_buf.delete();
                put_random($urandom_range(1, 12));
            end else begin
                build_random_file();
            end
            send_file();
        end
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (2) begin
            build_random_file();
            send_file();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    // Result sink: random stall bursts
    always @(negedge clk) begin
        if (stall_left != 0) begin
            result_if.ready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            result_if.ready = 1'b0;
            stall_left = $urandom_range(0, 8);
        end else begin
            result_if.ready = 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            got_res = {result_if.kind, result_if.payload_byte, result_if.smp_rate,
                       result_if.channel_count, result_if.bits_per_sample,
                       result_if.data_length, result_if.error_code, result_if.last};
            case (got_res.kind)
                KIND_PAYLOAD: payload_seen++;
                KIND_HEADER:  headers_seen++;
                KIND_ERROR:   errors_seen++;
                default:      truncs_seen++;
            endcase
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none actual %0h", $time, got_res);
                fail_count++;
            end else begin
                want_res = pending_results[0];
                pending_results.delete(0);
                check_field("kind", 32'(want_res.kind), 32'(got_res.kind));
                check_field("payload_byte", 32'(want_res.payload_byte),
                            32'(got_res.payload_byte));
                check_field("smp_rate", want_res.smp_rate, got_res.smp_rate);
                check_field("channel_count", 32'(want_res.channel_count),
                            32'(got_res.channel_count));
                check_field("bits_per_sample", 32'(want_res.bits_per_sample),
                            32'(got_res.bits_per_sample));
                check_field("data_length", want_res.data_length, got_res.data_length);
                check_field("error_code", 32'(want_res.error_code),
                            32'(got_res.error_code));
                check_field("last", 32'(want_res.last), 32'(got_res.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("wav_header_parser: mismatch");
            $finish;
        end
    end

    initial begin
        rst_n                = 1'b0;
        idle_on              = 1'b1;
        stall_left           = 0;
        byte_if.valid        = 1'b0;
        byte_if.in_byte      = 8'h00;
        byte_if.end_of_input = 1'b0;
        result_if.ready      = 1'b0;
        fail_count           = 0;
        cycle_count          = 0;
        files_sent           = 0;
        bytes_sent           = 0;
        headers_seen         = 0;
        payload_seen         = 0;
        errors_seen          = 0;
        truncs_seen          = 0;
        reset_parser();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_valid_file();
        test_tag_errors();
        test_chunk_errors();
        test_odd_and_repeated();
        test_field_extremes();
        test_early_end();
        test_random_files();
        test_no_idle();

        @(negedge clk);
        byte_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d files (%0d bytes); checked %0d headers, %0d payload bytes,",
                 files_sent, bytes_sent, headers_seen, payload_seen);
        $display("%0d error results and %0d truncations.", errors_seen, truncs_seen);
        if (fail_count == 0)
            $display("wav_header_parser: match");
        else
            $display("wav_header_parser: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/wavhp_pkg.sv
rtl/wavhp_if.sv
rtl/wavhp_core.sv
rtl/wavhp_rq.sv
rtl/wav_header_parser.sv
tb/sv/tb_wav_header_parser.sv
